/* src/tpdf_dither_quantizer_top_defines.svh */
// Assertion macros used by the quantiser RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef TPDF_DITHER_QUANTIZER_TOP_DEFINES_SVH
`define TPDF_DITHER_QUANTIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdq assertion failed");

`else

`define TDQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/tdq_pkg.sv */
`timescale 1ns / 1ps

package tdq_pkg;

	// Linear congruential generator.
	localparam logic [31:0] LCG_MUL  = 32'd1664525;
	localparam logic [31:0] LCG_ADD  = 32'd1013904223;
	localparam logic [31:0] LCG_SEED = 32'h2545F491;

	// Output width selection held in the configuration register.
	localparam logic MODE_16 = 1'b0;
	localparam logic MODE_24 = 1'b1;

	// Left shifts that take a Q3.28 sample into units of 2^-24 output LSB.
	localparam int SHIFT_16 = 11;
	localparam int SHIFT_24 = 19;

	// Width of the internal sum and of the floored quotient.
	localparam int SUM_W = 53;
	localparam int QUO_W = SUM_W - 24;

	localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(64'sd8388608);

	localparam logic signed [QUO_W-1:0] MAX_16 = QUO_W'(32'sd32767);
	localparam logic signed [QUO_W-1:0] MIN_16 = QUO_W'(-32'sd32768);
	localparam logic signed [QUO_W-1:0] MAX_24 = QUO_W'(32'sd8388607);
	localparam logic signed [QUO_W-1:0] MIN_24 = QUO_W'(-32'sd8388608);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW_A,
		ST_DRAW_B,
		ST_FINISH
	} tdq_state_t;

endpackage

/* src/tdq_channels.sv */
`timescale 1ns / 1ps

// Input sample channel.
interface tdq_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_in;
	logic               last_in_block;

	modport source(output valid, output sample_in, output last_in_block, input ready);
	modport sink(input valid, input sample_in, input last_in_block, output ready);
endinterface

// Result channel.
interface tdq_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] quantized_sample;
	logic               last_out;

	modport source(output valid, output quantized_sample, output last_out, input ready);
	modport sink(input valid, input quantized_sample, input last_out, output ready);
endinterface

// Configuration write channel for the single output width register.
interface tdq_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* src/tdq_lcg.sv */
`timescale 1ns / 1ps

// Noise generator word with its multiply-add unit, stepped once per strobe.
module tdq_lcg
	import tdq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	output logic [31:0] word
);

	logic [31:0] gen_q;
	logic [31:0] gen_next;

	assign gen_next = 32'(gen_q * LCG_MUL) + LCG_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= LCG_SEED;
		end else if (step) begin
			gen_q <= gen_next;
		end
	end

	assign word = gen_q;

endmodule

/* src/tpdf_dither_quantizer_top.sv */
// TPDF dither quantiser. Each beat on the sample channel carries one signed Q3.28
// audio sample (1.0 is full scale) and a last-of-block flag; for each one the block
// returns one beat holding the sample scaled to 16 or 24 bits, with triangular dither
// of plus or minus one LSB and half an LSB added, floored and saturated to the signed
// range of that width (16-bit results are sign-extended to the 24-bit field), and the
// flag copied through. The dither comes from a 32-bit linear congruential generator,
// seeded 0x2545F491 at reset and stepped twice per sample through a single
// multiply-add unit. After the sample beat is accepted, states DRAW_A and DRAW_B
// each take one generator step in the shared multiplier, and state FINISH does the
// wide add, floor and saturation into the output register. The next sample is taken
// only in idle, after FINISH, so a new sample is never taken while the last one is
// still being worked on. A finished result may wait in the output register while
// the next sample is taken in and worked on; the next result then waits until the
// previous one has been taken, and the input stays stalled meanwhile. The output
// width is written through the configuration channel, which is always ready, and
// must only be changed while no sample is in flight.
`timescale 1ns / 1ps

`include "tpdf_dither_quantizer_top_defines.svh"

module tpdf_dither_quantizer_top
	import tdq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tdq_sample_if.sink  sample_ch,
	tdq_result_if.source result_ch,
	tdq_cfg_if.sink     cfg_ch
);

	// Sequencer state and the strobes it raises.
	tdq_state_t state_q;
	tdq_state_t state_next;
	logic       take_sample;
	logic       gen_step;
	logic       load_a;
	logic       load_result;

	// Captured sample, first dither draw and configuration.
	logic signed [31:0] sample_q;
	logic               last_q;
	logic [23:0]        draw_a_q;
	logic               mode_q;

	// Output register.
	logic               res_valid_q;
	logic signed [23:0] res_sample_q;
	logic               res_last_q;
	logic               res_taken;

	// Arithmetic of the final cycle.
	logic [31:0]              gen_word;
	logic signed [24:0]       dither;
	logic signed [SUM_W-1:0]  sample_ext;
	logic signed [SUM_W-1:0]  scaled;
	logic signed [SUM_W-1:0]  sum;
	logic signed [QUO_W-1:0]  quotient;
	logic signed [QUO_W-1:0]  limit_hi;
	logic signed [QUO_W-1:0]  limit_lo;
	logic signed [QUO_W-1:0]  clamped;

	// The configuration register is always writable.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_16;
		end else if (cfg_ch.valid) begin
			mode_q <= cfg_ch.data;
		end
	end

	// One shared multiply-add serves both generator steps.
	tdq_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (gen_step),
		.word   (gen_word)
	);

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_ch.valid) begin
					state_next = ST_DRAW_A;
				end
			end
			ST_DRAW_A: begin
				state_next = ST_DRAW_B;
			end
			ST_DRAW_B: begin
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (!res_valid_q || result_ch.ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		sample_ch.ready = 1'b0;
		gen_step        = 1'b0;
		load_a          = 1'b0;
		load_result     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ch.ready = 1'b1;
			end
			ST_DRAW_A: begin
				gen_step = 1'b1;
			end
			ST_DRAW_B: begin
				// The word now holds the first draw; capture it and step again.
				gen_step = 1'b1;
				load_a   = 1'b1;
			end
			ST_FINISH: begin
				load_result = !res_valid_q || result_ch.ready;
			end
			default: begin
				sample_ch.ready = 1'b0;
			end
		endcase
	end

	assign take_sample = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			sample_q <= sample_ch.sample_in;
			last_q   <= sample_ch.last_in_block;
		end
		if (load_a) begin
			draw_a_q <= gen_word[31:8];
		end
	end

	// In the finishing cycle the generator word holds the second draw. The sum is kept
	// in units of 2^-24 output LSB, so the floor is simply its upper bits.
	always_comb begin
		dither     = $signed({1'b0, draw_a_q}) - $signed({1'b0, gen_word[31:8]});
		sample_ext = SUM_W'(sample_q);
		scaled     = (mode_q == MODE_24) ? (sample_ext <<< SHIFT_24) : (sample_ext <<< SHIFT_16);
		sum        = scaled + SUM_W'(dither) + HALF_LSB;
		quotient   = sum[SUM_W-1:24];
		limit_hi   = (mode_q == MODE_24) ? MAX_24 : MAX_16;
		limit_lo   = (mode_q == MODE_24) ? MIN_24 : MIN_16;
		if (quotient > limit_hi) begin
			clamped = limit_hi;
		end else if (quotient < limit_lo) begin
			clamped = limit_lo;
		end else begin
			clamped = quotient;
		end
	end

	assign res_taken = res_valid_q && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_result) begin
			res_valid_q <= 1'b1;
		end else if (res_taken) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			res_sample_q <= clamped[23:0];
			res_last_q   <= last_q;
		end
	end

	assign result_ch.valid            = res_valid_q;
	assign result_ch.quantized_sample = res_sample_q;
	assign result_ch.last_out         = res_last_q;

	// An accepted sample always starts the first generator step next.
	`TDQ_ASSERT_NEXT(a_take_starts_draw, clk, arst_n, take_sample, state_q == ST_DRAW_A)
	// The generator only moves during the two draw steps.
	`TDQ_ASSERT_SAME(a_step_in_draw, clk, arst_n, gen_step,
		state_q == ST_DRAW_A || state_q == ST_DRAW_B)
	// A finished result never overwrites one that has not been taken.
	`TDQ_ASSERT_SAME(a_no_overwrite, clk, arst_n, load_result,
		!res_valid_q || result_ch.ready)
	// In 16-bit mode a held result is a sign-extended 16-bit value.
	`TDQ_ASSERT_SAME(a_range_16, clk, arst_n, res_valid_q && mode_q == MODE_16,
		res_sample_q[23:15] == 9'h000 || res_sample_q[23:15] == 9'h1FF)

endmodule

/* sim/tpdf_dither_quantizer_top_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the TPDF dither quantiser. Samples go in over the sample
// channel, every accepted beat is run through a local model of the dither generator
// and quantiser, and every result beat is checked against the oldest prediction.
module tpdf_dither_quantizer_top_test;
	import tdq_pkg::*;

	// One 16-bit LSB is 2^13 in Q3.28 and one 24-bit LSB is 2^5.
	localparam logic signed [31:0] FULL_SCALE = 32'sh1000_0000;
	localparam logic signed [31:0] LSB_16     = 32'sh0000_2000;
	localparam logic signed [31:0] LSB_24     = 32'sh0000_0020;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int LONG_HOLD    = 150;
	localparam int PHASE_ITEMS  = 110;
	localparam int SETTLE_TICKS = 10;

	// Shapes of random sample, so that saturation, full scale and the region
	// around zero are all reached often enough.
	typedef enum logic [2:0] {
		SHAPE_ANY,
		SHAPE_IN_RANGE,
		SHAPE_FULL_SCALE,
		SHAPE_NEAR_ZERO,
		SHAPE_EXTREME
	} sample_shape_t;

	typedef struct {
		logic signed [23:0] code;
		logic               last;
	} quantised_beat_t;

	logic clk;
	logic arst_n;

	tdq_sample_if sample_ch();
	tdq_result_if result_ch();
	tdq_cfg_if    cfg_ch();

	tpdf_dither_quantizer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// Local copy of the generator word and of the width register.
	logic [31:0] dither_state;
	logic        width_mode;

	quantised_beat_t expected_beats[$];

	int  mismatch_count;
	int  cycle_count;
	int  hold_requests;
	bit  sender_gaps;
	bit  receiver_stalls;
	bit  quiet_tail;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the run must end well inside the limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tpdf_dither_quantizer_top_test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Steps the generator twice, then scales the sample into units of 2^-24 LSB,
	// adds the triangular dither and half an LSB, floors and saturates.
	function automatic logic signed [23:0] predict_quantised(input logic signed [31:0] smp);
		longint signed draw_a;
		longint signed draw_b;
		longint signed total;
		longint signed quo;
		longint signed hi;
		longint signed lo;
		dither_state = dither_state * LCG_MUL + LCG_ADD;
		draw_a = longint'({40'd0, dither_state[31:8]});
		dither_state = dither_state * LCG_MUL + LCG_ADD;
		draw_b = longint'({40'd0, dither_state[31:8]});
		if (width_mode == MODE_24) begin
			total = longint'(smp) <<< SHIFT_24;
			hi = 64'sd8388607;
			lo = -64'sd8388608;
		end else begin
			total = longint'(smp) <<< SHIFT_16;
			hi = 64'sd32767;
			lo = -64'sd32768;
		end
		total = total + draw_a - draw_b + (64'sd1 <<< 23);
		// An arithmetic shift of a signed value is a floor division.
		quo = total >>> 24;
		if (quo > hi)
			quo = hi;
		if (quo < lo)
			quo = lo;
		return quo[23:0];
	endfunction

	function automatic logic signed [31:0] random_sample();
		sample_shape_t shape;
		logic [31:0]   sign_flip;
		shape = sample_shape_t'($urandom_range(SHAPE_ANY, SHAPE_EXTREME));
		sign_flip = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		case (shape)
			SHAPE_IN_RANGE: begin
				return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
			end
			SHAPE_FULL_SCALE: begin
				return (FULL_SCALE + 32'($urandom_range(0, 8191)) - 32'd4096) ^ sign_flip;
			end
			SHAPE_NEAR_ZERO: begin
				return 32'($urandom_range(0, 32'h4000)) - 32'h2000;
			end
			SHAPE_EXTREME: begin
				return 32'h7FFF_FFFF - 32'($urandom_range(0, 255)) ^ sign_flip;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Sends one sample beat, with an optional burst of idle cycles before it. The
	// valid line is left high so that back-to-back beats follow without a gap; any
	// caller that stops sending lowers it through release_and_drain.
	task automatic send_sample(input logic signed [31:0] smp, input logic last);
		quantised_beat_t prediction;
		int              gap;
		if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			sample_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.valid         <= 1'b1;
		sample_ch.sample_in     <= smp;
		sample_ch.last_in_block <= last;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		prediction.code = predict_quantised(smp);
		prediction.last = last;
		expected_beats.push_back(prediction);
	endtask

	// Drops valid and waits until every predicted result has come back, then waits
	// out a settling period so that the pipeline is certainly empty.
	task automatic release_and_drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// The width register may only change while nothing is in flight.
	task automatic write_width_mode(input logic mode);
		release_and_drain();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= mode;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		width_mode = mode;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Zero, full scale both ways, just inside and just beyond, the extremes of
	// the 32-bit field, alternating bit patterns, one LSB both ways and half an LSB.
	task automatic send_corner_samples(input logic signed [31:0] lsb);
		logic signed [31:0] corner [12];
		corner = '{32'sh0, FULL_SCALE, -FULL_SCALE, FULL_SCALE - 32'sd1,
			FULL_SCALE + 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555,
			32'shAAAA_AAAA, lsb, -lsb, lsb >>> 1};
		for (int i = 0; i < 12; i++)
			send_sample(corner[i], i[0]);
		release_and_drain();
	endtask

	task automatic send_random_run(input int count);
		for (int i = 0; i < count; i++)
			send_sample(random_sample(), $urandom_range(0, 7) == 0);
	endtask

	// The register is left at its reset value, so this also checks that reset
	// selects sixteen-bit output with sign extension into the 24-bit field.
	task automatic test_reset_width_16();
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		send_corner_samples(LSB_16);
	endtask

	task automatic test_corners_width_24();
		write_width_mode(MODE_24);
		send_corner_samples(LSB_24);
	endtask

	// Several phases with the width changed between them; each phase decides
	// on its own whether either side idles, which gives stretches without gaps.
	task automatic test_random_widths();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				write_width_mode(logic'($urandom_range(0, 1)));
			else
				write_width_mode(phase[0] ? MODE_24 : MODE_16);
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			send_random_run(PHASE_ITEMS);
			release_and_drain();
		end
	endtask

	// The receiver holds off for a long stretch while samples keep coming, so
	// the output register and the working stage fill and the input stalls.
	task automatic test_output_backpressure();
		release_and_drain();
		sender_gaps = 1'b0;
		@(posedge clk);
		hold_requests++;
		send_random_run(40);
		release_and_drain();
		sender_gaps = 1'b1;
	endtask

	// The sender stops until every result is back before starting again.
	task automatic test_drain_pause();
		write_width_mode(MODE_16);
		for (int round = 0; round < 3; round++) begin
			send_random_run(15);
			release_and_drain();
		end
	endtask

	// Last part of the run: no idling on either side, full rate streaming.
	task automatic test_streaming_tail();
		write_width_mode(MODE_24);
		quiet_tail = 1'b1;
		send_random_run(100);
		release_and_drain();
	endtask

	// Result side ready. A test hold request gives one long stretch of low ready,
	// counted here; else, with stalls enabled, ready drops in short random bursts.
	initial begin : result_receiver
		int hold_left;
		int stall_left;
		int holds_served;
		hold_left = 0;
		stall_left = 0;
		holds_served = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (receiver_stalls && !quiet_tail && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Every result beat is matched against the oldest prediction, field by field.
	always @(posedge clk) begin : result_checker
		quantised_beat_t oldest;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing expected",
					result_ch.quantized_sample));
			end else begin
				oldest = expected_beats.pop_front();
				if (result_ch.quantized_sample !== oldest.code)
					report_mismatch($sformatf("quantized_sample %0d, expected %0d",
						result_ch.quantized_sample, oldest.code));
				if (result_ch.last_out !== oldest.last)
					report_mismatch($sformatf("last_out %b, expected %b",
						result_ch.last_out, oldest.last));
			end
		end
	end

	initial begin
		sample_ch.valid         = 1'b0;
		sample_ch.sample_in     = '0;
		sample_ch.last_in_block = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.data             = MODE_16;
		arst_n                  = 1'b0;
		dither_state            = LCG_SEED;
		width_mode              = MODE_16;
		mismatch_count          = 0;
		cycle_count             = 0;
		hold_requests           = 0;
		sender_gaps             = 1'b1;
		receiver_stalls         = 1'b1;
		quiet_tail              = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_width_16();
		test_corners_width_24();
		test_random_widths();
		test_output_backpressure();
		test_drain_pause();
		test_streaming_tail();

		// The last drain has already emptied the prediction store; a further settling
		// wait catches any stray beat that the block might still send.
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tpdf_dither_quantizer_top_test passed");
		end else begin
			$display("tpdf_dither_quantizer_top_test failed");
		end
		$finish;
	end

endmodule
